FILE: src/afr_pkg.sv
// Shared constants, types and codes for the API frame receiver.
package afr_pkg;

   localparam int BUF_BYTES    = 64;
   localparam int IDX_W        = $clog2(BUF_BYTES);
   localparam int CNT_W        = $clog2(BUF_BYTES + 1);
   localparam int ADDR_W       = IDX_W + 1;
   localparam int MEM_DEPTH    = 2 ** ADDR_W;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int LEN_W        = 16;
   localparam int TOTAL_W      = LEN_W + 1;
   localparam int CSR_IDX_W    = 8;

   localparam logic [7:0] START_BYTE    = 8'h7E;
   localparam logic [7:0] AT_TYPE_RST   = 8'h88;
   localparam logic [7:0] DATA_TYPE_RST = 8'h81;
   localparam int         HEADER_EXTRA  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_AT_RESPONSE_TYPE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_FRAME_TYPE  = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_TYPE,
      PH_BODY
   } phase_type;

   typedef struct packed {
      logic             err;
      logic             kind;
      logic             bank;
      logic [CNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

endpackage

FILE: src/afr_front.sv
// Front end: configuration registers, frame parser and frame buffer writes.
module afr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          csr_valid,
   input  logic [afr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data,
   input  logic                          queue_full,
   output afr_pkg::wr_type               wr,
   output logic                          push,
   output afr_pkg::job_type              job
);
   import afr_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               kind_ff, kind_in;
   logic               bank_ff, bank_in;
   logic [7:0]         at_type_ff, data_type_ff;
   logic               accept;
   logic [CNT_W-1:0]   cnt_st;
   logic [TOTAL_W-1:0] total;
   logic [LEN_W-1:0]   new_len;
   logic               can_store;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         at_type_ff   <= AT_TYPE_RST;
         data_type_ff <= DATA_TYPE_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_AT_RESPONSE_TYPE) begin
            at_type_ff <= csr_data;
         end
         if (csr_index == CSR_DATA_FRAME_TYPE) begin
            data_type_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         cnt_ff   <= '0;
         len_ff   <= '0;
         kind_ff  <= 1'b0;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         kind_ff  <= kind_in;
         bank_ff  <= bank_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      kind_in   = kind_ff;
      bank_in   = bank_ff;
      push      = 1'b0;
      job       = '0;
      can_store = cnt_ff < CNT_W'(BUF_BYTES);
      cnt_st    = can_store ? cnt_ff + CNT_W'(1) : cnt_ff;
      total     = TOTAL_W'(len_ff) + TOTAL_W'(HEADER_EXTRA);
      new_len   = {len_ff[LEN_W-1:8], req_rx_byte};
      wr.en     = 1'b0;
      wr.addr   = {bank_ff, cnt_ff[IDX_W-1:0]};
      wr.data   = req_rx_byte;
      job.bank  = bank_ff;
      job.count = cnt_st;
      job.kind  = kind_ff;
      if (accept) begin
         case (phase_ff)
            PH_LEN_HI: begin
               wr.en    = can_store;
               cnt_in   = cnt_st;
               len_in   = {req_rx_byte, 8'h00};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               wr.en  = can_store;
               cnt_in = cnt_st;
               len_in = new_len;
               if (TOTAL_W'(new_len) + TOTAL_W'(HEADER_EXTRA) > TOTAL_W'(BUF_BYTES)) begin
                  push     = 1'b1;
                  job.err  = 1'b1;
                  cnt_in   = '0;
                  phase_in = PH_HUNT;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               wr.en  = can_store;
               cnt_in = cnt_st;
               if (req_rx_byte == at_type_ff || req_rx_byte == data_type_ff) begin
                  kind_in  = (req_rx_byte != at_type_ff);
                  job.kind = kind_in;
                  if (TOTAL_W'(cnt_st) >= total) begin
                     push     = 1'b1;
                     bank_in  = !bank_ff;
                     cnt_in   = '0;
                     phase_in = PH_HUNT;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end else begin
                  cnt_in   = '0;
                  phase_in = PH_HUNT;
               end
            end
            PH_BODY: begin
               wr.en  = can_store;
               cnt_in = cnt_st;
               if (TOTAL_W'(cnt_st) >= total || cnt_st >= CNT_W'(BUF_BYTES)) begin
                  push     = 1'b1;
                  bank_in  = !bank_ff;
                  cnt_in   = '0;
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (req_rx_byte == START_BYTE) begin
                  wr.en    = 1'b1;
                  wr.addr  = {bank_ff, {IDX_W{1'b0}}};
                  cnt_in   = CNT_W'(1);
                  phase_in = PH_LEN_HI;
               end
            end
         endcase
      end
   end

endmodule

FILE: src/afr_queue.sv
// Short job queue between the parser and the frame emitter.
module afr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  afr_pkg::job_type push_job,
   input  logic             pop,
   output logic             head_valid,
   output afr_pkg::job_type head,
   output logic             full
);
   import afr_pkg::*;

   job_type           ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in;
   logic [QPTR_W-1:0] rp_ff, rp_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign head_valid = cnt_ff != '0;
   assign head       = ent_ff[rp_ff];
   assign full       = cnt_ff == QCNT_W'(QUEUE_DEPTH);

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + QPTR_W'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_job;
      end
   end

endmodule

FILE: src/afr_back.sv
// Back end: two-bank frame buffer and the result beat emitter.
module afr_back (
   input  logic             clock,
   input  logic             reset,
   input  afr_pkg::wr_type  wr,
   input  logic             head_valid,
   input  afr_pkg::job_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_frame_kind,
   output logic             rsp_status,
   output logic             rsp_last
);
   import afr_pkg::*;

   logic [7:0]       store_mem [MEM_DEPTH];
   logic [7:0]       rdata_ff;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic             p_err_ff, p_err_in;
   logic             p_last_ff, p_last_in;
   logic             p_kind_ff, p_kind_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff;
   logic             kind_ff, status_ff, last_ff;
   logic             load, issue, last_rd;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_kind = kind_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

   always_comb begin
      load         = pend_ff && (!rsp_valid_ff || rsp_ready);
      issue        = head_valid && (!pend_ff || load);
      last_rd      = head.err || (CNT_W'(ptr_ff) + CNT_W'(1) == head.count);
      pop          = issue && last_rd;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      p_err_in     = p_err_ff;
      p_last_in    = p_last_ff;
      p_kind_in    = p_kind_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         pend_in      = 1'b0;
      end
      if (issue) begin
         pend_in   = 1'b1;
         p_err_in  = head.err;
         p_last_in = last_rd;
         p_kind_in = head.kind && !head.err;
         ptr_in    = last_rd ? '0 : ptr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_err_ff  <= p_err_in;
      p_last_ff <= p_last_in;
      p_kind_ff <= p_kind_in;
      if (load) begin
         byte_ff   <= p_err_ff ? 8'h00 : rdata_ff;
         kind_ff   <= p_kind_ff;
         status_ff <= p_err_ff;
         last_ff   <= p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (issue && !head.err) begin
         rdata_ff <= store_mem[{head.bank, ptr_ff}];
      end
   end

endmodule

FILE: src/api_frame_receiver.sv
// Top level of the API frame receiver: parser, job queue and frame emitter.
//
// Serial bytes enter one beat per cycle while req_ready is high. The parser
// hunts for the 0x7E start byte, reads a 16-bit length and a type byte, and
// stores the frame in one of two 64-byte buffer banks. A finished frame of n
// bytes (4 to 64) leaves as n result beats, one per cycle while the sink is
// ready, through a buffer read register and an output register; a frame too
// long for a bank leaves as one error beat. Input beats are taken while fewer
// than two finished frames or errors wait in the two-entry job queue, so the
// parser can fill one bank while the other is being emitted. Configuration
// writes are always taken and need no clearing pass after reset.
module api_frame_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_frame_byte,
   output logic                          rsp_frame_kind,
   output logic                          rsp_status,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [afr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);
   import afr_pkg::*;

   wr_type  wr;
   job_type push_job, head;
   logic    push, pop, head_valid, queue_full;

   assign csr_ready = 1'b1;

   afr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rx_byte(req_rx_byte),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .wr         (wr),
      .push       (push),
      .job        (push_job)
   );

   afr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_valid(head_valid),
      .head      (head),
      .full      (queue_full)
   );

   afr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .wr            (wr),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_frame_kind(rsp_frame_kind),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule
